// ===== hw/rtl/pbin_pkg.sv =====
// Shared types, constants and functions of the polarization map binner.
// Holds the quarter-wave sine table and the saturating add used by the back end.
// No dependencies.
package pbin_pkg;

  localparam int NUM_PIXELS_DEF   = 65536;
  localparam int NUM_BANDS_DEF    = 4;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int ACC_WIDTH_DEF    = 48;

  localparam int ROM_DEPTH = 1024;
  localparam int ROM_AW    = $clog2(ROM_DEPTH);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int ONE_Q15   = 32767;
  localparam int HIT_WIDTH = 32;
  localparam int ACC_WIDE  = 66;

  typedef logic [15:0] rom_t [ROM_DEPTH];

  typedef struct packed {
    logic [ROM_AW-1:0] addr;
    logic              full;
    logic              neg;
  } trig_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_WB
  } st_t;

  function automatic rom_t build_rom();
    rom_t               r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      x    = (64'(k) * HALF_PI_Q30) >> 10;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) != 0) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (64'(sum) * 64'(ONE_Q15) + 64'(1 << 29)) >> 30;
      if (v > 64'(ONE_Q15)) begin
        v = 64'(ONE_Q15);
      end
      r[k] = v[15:0];
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic trig_idx_t trig_idx(input logic [15:0] ph);
    trig_idx_t         t;
    logic [ROM_AW-1:0] i;
    i      = ph[13:4];
    t.addr = ph[14] ? ROM_AW'(~i + ROM_AW'(1)) : i;
    t.full = ph[14] && (i == '0);
    t.neg  = ph[15];
    return t;
  endfunction

  function automatic logic signed [ACC_WIDE-1:0] sat_acc(
    input logic signed [ACC_WIDE-1:0] acc,
    input logic signed [ACC_WIDE-1:0] d,
    input int unsigned                aw
  );
    logic signed [ACC_WIDE-1:0] mx;
    logic signed [ACC_WIDE-1:0] mn;
    logic signed [ACC_WIDE-1:0] s;
    mx = (ACC_WIDE'(1) <<< (aw - 1)) - ACC_WIDE'(1);
    mn = -mx - ACC_WIDE'(1);
    s  = acc + d;
    if (s > mx) begin
      return mx;
    end
    if (s < mn) begin
      return mn;
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/polarization_map_binner.sv =====
// Polarization map binner: per-pixel and per-band polarization accumulators.
// Input items enter on the s_axis channel, read results leave on m_axis.
// An accumulate item (tuser 0) updates the band sums of its pixel and band and,
// with with_geometry set, the pixel hit count and angle products; it gives no
// result. A read item (tuser 1) gives one result with all sums of its pixel
// and band, or all zeros when pixel or band is out of range.
// Each item passes the back end as table and memory read, then multiply, then
// saturating write-back; that read-modify-write sequencer finishes one item
// before it takes the next from the queue.
// Two queued commands decouple the input side from the back end.
// After reset a clearing pass zeroes every accumulator, stepping through all
// NUM_PIXELS*NUM_BANDS band addresses; s_axis_tready stays low meanwhile.
// A stalled m_axis holds its result; the back end waits on the next read and
// the queue fills, then s_axis_tready drops.
// Depends on pbin_pkg, pbin_front, pbin_queue and pbin_back.
module polarization_map_binner import pbin_pkg::*; #(
  parameter int NUM_PIXELS   = NUM_PIXELS_DEF,
  parameter int NUM_BANDS    = NUM_BANDS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = ACC_WIDTH_DEF,
  localparam int IN_W        = 35 + 2 * SAMPLE_WIDTH,
  localparam int IN_TW       = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W       = HIT_WIDTH + 6 * ACC_WIDTH,
  localparam int OUT_TW      = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // pixel, band, angle, tod_sum, tod_diff, with_geometry
  input  logic [IN_TW-1:0]  s_axis_tdata,
  // req_type
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // hits, cos_sq_sum, sin_sq_sum, cos_sin_sum, band_sum, band_cos_diff, band_sin_diff
  output logic [OUT_TW-1:0] m_axis_tdata
);

  localparam int PAW   = $clog2(NUM_PIXELS);
  localparam int BAW   = $clog2(NUM_PIXELS * NUM_BANDS);
  localparam int CMD_W = 3 + BAW + PAW + 2 * $bits(trig_idx_t) + 2 * SAMPLE_WIDTH;

  logic             clearing;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  logic [CMD_W-1:0] q_data;
  logic [CMD_W-1:0] q_head;

  pbin_front #(
    .NUM_PIXELS   (NUM_PIXELS),
    .NUM_BANDS    (NUM_BANDS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .PAW          (PAW),
    .BAW          (BAW),
    .IN_TW        (IN_TW),
    .CMD_W        (CMD_W)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clearing      (clearing),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  pbin_queue #(
    .W (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  pbin_back #(
    .NUM_PIXELS   (NUM_PIXELS),
    .NUM_BANDS    (NUM_BANDS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH),
    .PAW          (PAW),
    .BAW          (BAW),
    .CMD_W        (CMD_W),
    .OUT_TW       (OUT_TW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_head        (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command queue popped while empty");

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("command queue full and empty at once");

endmodule

// ===== hw/rtl/pbin_front.sv =====
// Input side of the binner: takes stream items, checks range, resolves trig indexes.
// Pushes one packed command per item into the command queue. Depends on pbin_pkg.
module pbin_front import pbin_pkg::*; #(
  parameter int NUM_PIXELS   = NUM_PIXELS_DEF,
  parameter int NUM_BANDS    = NUM_BANDS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int PAW          = $clog2(NUM_PIXELS),
  parameter int BAW          = $clog2(NUM_PIXELS * NUM_BANDS),
  parameter int IN_TW        = 8,
  parameter int CMD_W        = 8
) (
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_TW-1:0] s_axis_tdata,
  input  logic             s_axis_tuser,
  input  logic             clearing,
  input  logic             q_full,
  output logic             q_push,
  output logic [CMD_W-1:0] q_data
);

  logic [15:0]             pixel;
  logic [1:0]              band;
  logic [15:0]             angle;
  logic [SAMPLE_WIDTH-1:0] tod_sum;
  logic [SAMPLE_WIDTH-1:0] tod_diff;
  logic                    with_geometry;
  logic                    ok;
  logic [15:0]             phase;
  trig_idx_t               s_idx;
  trig_idx_t               c_idx;
  logic [PAW-1:0]          pix_addr;
  logic [BAW-1:0]          band_addr;

  assign pixel         = s_axis_tdata[15:0];
  assign band          = s_axis_tdata[17:16];
  assign angle         = s_axis_tdata[33:18];
  assign tod_sum       = s_axis_tdata[34 +: SAMPLE_WIDTH];
  assign tod_diff      = s_axis_tdata[34 + SAMPLE_WIDTH +: SAMPLE_WIDTH];
  assign with_geometry = s_axis_tdata[34 + 2 * SAMPLE_WIDTH];

  assign ok        = (32'(pixel) < 32'(NUM_PIXELS)) && (32'(band) < 32'(NUM_BANDS));
  assign phase     = {angle[14:0], 1'b0};
  assign s_idx     = trig_idx(phase);
  assign c_idx     = trig_idx(phase + 16'h4000);
  assign pix_addr  = PAW'(pixel);
  assign band_addr = BAW'(BAW'(pixel) * BAW'(NUM_BANDS) + BAW'(band));

  assign s_axis_tready = !q_full && !clearing;
  assign q_push        = s_axis_tvalid && s_axis_tready;
  assign q_data        = {s_axis_tuser, ok, with_geometry, band_addr, pix_addr,
                          s_idx, c_idx, tod_sum, tod_diff};

endmodule

// ===== hw/rtl/pbin_queue.sv =====
// Two-entry command queue between the front and back of the binner.
// Depends on pbin_pkg only through the common import.
module pbin_queue import pbin_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  assign head  = slot[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

endmodule

// ===== hw/rtl/pbin_back.sv =====
// Back end of the binner: clearing pass, accumulator memories, sine table,
// read-modify-write sequencer and the result register. Depends on pbin_pkg.
module pbin_back import pbin_pkg::*; #(
  parameter int NUM_PIXELS   = NUM_PIXELS_DEF,
  parameter int NUM_BANDS    = NUM_BANDS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int ACC_WIDTH    = ACC_WIDTH_DEF,
  parameter int PAW          = $clog2(NUM_PIXELS),
  parameter int BAW          = $clog2(NUM_PIXELS * NUM_BANDS),
  parameter int CMD_W        = 8,
  parameter int OUT_TW       = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CMD_W-1:0]  q_head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              clearing,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_TW-1:0] m_axis_tdata
);

  localparam int TOTAL = NUM_PIXELS * NUM_BANDS;
  localparam int PW    = 17 + SAMPLE_WIDTH;

  logic [ACC_WIDTH-1:0] band_sum_mem [TOTAL];
  logic [ACC_WIDTH-1:0] band_cos_mem [TOTAL];
  logic [ACC_WIDTH-1:0] band_sin_mem [TOTAL];
  logic [HIT_WIDTH-1:0] hit_mem      [NUM_PIXELS];
  logic [ACC_WIDTH-1:0] cos_sq_mem   [NUM_PIXELS];
  logic [ACC_WIDTH-1:0] sin_sq_mem   [NUM_PIXELS];
  logic [ACC_WIDTH-1:0] cos_sin_mem  [NUM_PIXELS];

  st_t state;
  st_t state_next;

  logic                    h_read;
  logic                    h_ok;
  logic                    h_geom;
  logic [BAW-1:0]          h_baddr;
  logic [PAW-1:0]          h_paddr;
  trig_idx_t               h_sidx;
  trig_idx_t               h_cidx;
  logic [SAMPLE_WIDTH-1:0] h_tsum;
  logic [SAMPLE_WIDTH-1:0] h_tdiff;

  logic                    c_read;
  logic                    c_ok;
  logic                    c_geom;
  logic [BAW-1:0]          c_baddr;
  logic [PAW-1:0]          c_paddr;
  logic                    c_sfull;
  logic                    c_sneg;
  logic                    c_cfull;
  logic                    c_cneg;
  logic [SAMPLE_WIDTH-1:0] c_tsum;
  logic [SAMPLE_WIDTH-1:0] c_tdiff;

  logic [15:0]          sin_q;
  logic [15:0]          cos_q;
  logic [ACC_WIDTH-1:0] bsum_q;
  logic [ACC_WIDTH-1:0] bcos_q;
  logic [ACC_WIDTH-1:0] bsin_q;
  logic [HIT_WIDTH-1:0] hit_q;
  logic [ACC_WIDTH-1:0] csq_q;
  logic [ACC_WIDTH-1:0] ssq_q;
  logic [ACC_WIDTH-1:0] cs_q;

  logic signed [16:0]   s_mag;
  logic signed [16:0]   c_mag;
  logic signed [16:0]   s_val;
  logic signed [16:0]   c_val;
  logic signed [PW-1:0] pcd;
  logic signed [PW-1:0] psd;
  logic signed [33:0]   pcc;
  logic signed [33:0]   pss;
  logic signed [33:0]   pcs;
  logic signed [PW-1:0] rcos;
  logic signed [PW-1:0] rsin;

  logic [BAW-1:0]       clr;
  logic                 wr_go;
  logic                 out_load;
  logic                 band_we;
  logic                 pix_we;
  logic [BAW-1:0]       band_wa;
  logic [PAW-1:0]       pix_wa;
  logic [ACC_WIDTH-1:0] n_bsum;
  logic [ACC_WIDTH-1:0] n_bcos;
  logic [ACC_WIDTH-1:0] n_bsin;
  logic [HIT_WIDTH-1:0] n_hit;
  logic [ACC_WIDTH-1:0] n_csq;
  logic [ACC_WIDTH-1:0] n_ssq;
  logic [ACC_WIDTH-1:0] n_cs;

  assign {h_read, h_ok, h_geom, h_baddr, h_paddr, h_sidx, h_cidx, h_tsum, h_tdiff} = q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr <= clr + BAW'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    wr_go      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr == BAW'(TOTAL - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_WB;
      end
      ST_WB: begin
        if (!c_read) begin
          wr_go      = c_ok;
          state_next = ST_IDLE;
        end else if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign clearing = (state == ST_CLEAR);

  // latch command, look up the table and read every accumulator
  always_ff @(posedge clk) begin
    if (q_pop) begin
      c_read  <= h_read;
      c_ok    <= h_ok;
      c_geom  <= h_geom;
      c_baddr <= h_baddr;
      c_paddr <= h_paddr;
      c_sfull <= h_sidx.full;
      c_sneg  <= h_sidx.neg;
      c_cfull <= h_cidx.full;
      c_cneg  <= h_cidx.neg;
      c_tsum  <= h_tsum;
      c_tdiff <= h_tdiff;
      sin_q   <= SINE_ROM[h_sidx.addr];
      cos_q   <= SINE_ROM[h_cidx.addr];
      bsum_q  <= band_sum_mem[h_baddr];
      bcos_q  <= band_cos_mem[h_baddr];
      bsin_q  <= band_sin_mem[h_baddr];
      hit_q   <= hit_mem[h_paddr];
      csq_q   <= cos_sq_mem[h_paddr];
      ssq_q   <= sin_sq_mem[h_paddr];
      cs_q    <= cos_sin_mem[h_paddr];
    end
  end

  assign s_mag = c_sfull ? 17'(ONE_Q15) : signed'({1'b0, sin_q});
  assign c_mag = c_cfull ? 17'(ONE_Q15) : signed'({1'b0, cos_q});
  assign s_val = c_sneg ? -s_mag : s_mag;
  assign c_val = c_cneg ? -c_mag : c_mag;

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      pcd <= PW'(c_val * signed'(c_tdiff));
      psd <= PW'(s_val * signed'(c_tdiff));
      pcc <= 34'(c_val * c_val);
      pss <= 34'(s_val * s_val);
      pcs <= 34'(c_val * s_val);
    end
  end

  assign rcos = (pcd + signed'(PW'(32768))) >>> 16;
  assign rsin = (psd + signed'(PW'(32768))) >>> 16;

  assign n_bsum = ACC_WIDTH'(sat_acc(ACC_WIDE'(signed'(bsum_q)),
                                     ACC_WIDE'(signed'(c_tsum)), ACC_WIDTH));
  assign n_bcos = ACC_WIDTH'(sat_acc(ACC_WIDE'(signed'(bcos_q)), ACC_WIDE'(rcos), ACC_WIDTH));
  assign n_bsin = ACC_WIDTH'(sat_acc(ACC_WIDE'(signed'(bsin_q)), ACC_WIDE'(rsin), ACC_WIDTH));
  assign n_csq  = ACC_WIDTH'(sat_acc(ACC_WIDE'(signed'(csq_q)), ACC_WIDE'(pcc), ACC_WIDTH));
  assign n_ssq  = ACC_WIDTH'(sat_acc(ACC_WIDE'(signed'(ssq_q)), ACC_WIDE'(pss), ACC_WIDTH));
  assign n_cs   = ACC_WIDTH'(sat_acc(ACC_WIDE'(signed'(cs_q)), ACC_WIDE'(pcs), ACC_WIDTH));
  assign n_hit  = (hit_q > {{(HIT_WIDTH-2){1'b1}}, 2'b01}) ? '1 : hit_q + HIT_WIDTH'(2);

  assign band_we = clearing || wr_go;
  assign pix_we  = (clearing && (32'(clr) < 32'(NUM_PIXELS))) || (wr_go && c_geom);
  assign band_wa = clearing ? clr : c_baddr;
  assign pix_wa  = clearing ? PAW'(clr) : c_paddr;

  always_ff @(posedge clk) begin
    if (band_we) begin
      band_sum_mem[band_wa] <= clearing ? '0 : n_bsum;
      band_cos_mem[band_wa] <= clearing ? '0 : n_bcos;
      band_sin_mem[band_wa] <= clearing ? '0 : n_bsin;
    end
    if (pix_we) begin
      hit_mem[pix_wa]     <= clearing ? '0 : n_hit;
      cos_sq_mem[pix_wa]  <= clearing ? '0 : n_csq;
      sin_sq_mem[pix_wa]  <= clearing ? '0 : n_ssq;
      cos_sin_mem[pix_wa] <= clearing ? '0 : n_cs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= c_ok ? OUT_TW'({bsin_q, bcos_q, bsum_q, cs_q, ssq_q, csq_q, hit_q}) : '0;
    end
  end

endmodule

// ===== sim/tb_polarization_map_binner.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of polarization_map_binner: directed table, then random
// accumulate/read transfers checked against an in-bench accumulator predictor.
// Depends on pbin_pkg and the polarization_map_binner RTL.
module tb_polarization_map_binner;
  import pbin_pkg::*;

  localparam int TD_W = 88;
  localparam int RD_W = 320;
  localparam longint ACC_MAX = (64'sd1 <<< 47) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint HIT_MAX = 64'd4294967295;
  localparam int N_RANDOM = 1430;

  typedef enum bit {REQ_ACC = 1'b0, REQ_READ = 1'b1} req_e;

  typedef struct {
    longint hits;
    longint cos_sq;
    longint sin_sq;
    longint cos_sin;
    longint bsum;
    longint bcos;
    longint bsin;
  } pix_sums_t;

  typedef struct {
    req_e        rq;
    bit [15:0]   pixel;
    bit [1:0]    band;
    bit [15:0]   angle;
    bit [23:0]   tsum;
    bit [23:0]   tdiff;
    bit          geo;
    bit          typed;
    pix_sums_t   want;
  } stim_row_t;

  logic            clk;
  logic            rst;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [TD_W-1:0] s_axis_tdata;
  logic            s_axis_tuser;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [RD_W-1:0] m_axis_tdata;

  polarization_map_binner i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  longint    hit_cnt [65536];
  longint    cos_sq_acc [65536];
  longint    sin_sq_acc [65536];
  longint    cos_sin_acc [65536];
  longint    band_sum_acc [262144];
  longint    band_cos_acc [262144];
  longint    band_sin_acc [262144];
  int        sine_tab [1024];
  pix_sums_t pending_reads [$];
  int        errors;
  int        n_sent;
  int        n_reads;
  int        n_checked;
  bit        calm;
  bit        hold_req;
  bit [15:0] hot_pixels [8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void fill_sine_tab();
    longint unsigned x, x2, term, v;
    longint          acc;
    for (int k = 0; k < 1024; k++) begin
      x    = (longint'(k) * 64'd1686629713) >> 10;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        acc  = n[0] ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      v = (longint'(acc) * 32767 + (64'd1 << 29)) >> 30;
      sine_tab[k] = (v > 32767) ? 32767 : int'(v);
    end
  endfunction

  function automatic longint trig_of(bit [15:0] ph);
    bit [9:0] i;
    longint   mag;
    i = ph[13:4];
    if (ph[14]) mag = (i == 0) ? 32767 : sine_tab[1024 - i];
    else mag = sine_tab[i];
    return ph[15] ? -mag : mag;
  endfunction

  function automatic longint sat_sum(longint a, longint d);
    longint s;
    s = a + d;
    if (s > ACC_MAX) return ACC_MAX;
    if (s < ACC_MIN) return ACC_MIN;
    return s;
  endfunction

  function automatic longint half_scale(longint p);
    return (p + 32768) >>> 16;
  endfunction

  // Apply one accepted transfer to the predicted accumulators.
  function automatic void bin_sample(stim_row_t r);
    int        bi;
    bit [15:0] ph;
    longint    c, s, d;
    bi = int'(r.pixel) * 4 + int'(r.band);
    if (r.rq == REQ_READ) begin
      n_reads++;
      if (r.typed) begin
        pending_reads.push_back(r.want);
      end else begin
        pending_reads.push_back('{hit_cnt[r.pixel], cos_sq_acc[r.pixel], sin_sq_acc[r.pixel],
                                  cos_sin_acc[r.pixel], band_sum_acc[bi], band_cos_acc[bi],
                                  band_sin_acc[bi]});
      end
      return;
    end
    ph = {r.angle[14:0], 1'b0};
    c  = trig_of(ph + 16'h4000);
    s  = trig_of(ph);
    d  = longint'($signed(r.tdiff));
    band_sum_acc[bi] = sat_sum(band_sum_acc[bi], longint'($signed(r.tsum)));
    band_cos_acc[bi] = sat_sum(band_cos_acc[bi], half_scale(c * d));
    band_sin_acc[bi] = sat_sum(band_sin_acc[bi], half_scale(s * d));
    if (r.geo) begin
      hit_cnt[r.pixel]     = (hit_cnt[r.pixel] + 2 > HIT_MAX) ? HIT_MAX : hit_cnt[r.pixel] + 2;
      cos_sq_acc[r.pixel]  = sat_sum(cos_sq_acc[r.pixel], c * c);
      sin_sq_acc[r.pixel]  = sat_sum(sin_sq_acc[r.pixel], s * s);
      cos_sin_acc[r.pixel] = sat_sum(cos_sin_acc[r.pixel], c * s);
    end
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
  endtask

  task automatic check_read();
    pix_sums_t w;
    n_checked++;
    if (pending_reads.size() == 0) begin
      report("unexpected read result", 0, 0);
      return;
    end
    w = pending_reads.pop_front();
    if (longint'(m_axis_tdata[31:0]) != w.hits)
      report("hits", longint'(m_axis_tdata[31:0]), w.hits);
    if (longint'($signed(m_axis_tdata[79:32])) != w.cos_sq)
      report("cos_sq_sum", longint'($signed(m_axis_tdata[79:32])), w.cos_sq);
    if (longint'($signed(m_axis_tdata[127:80])) != w.sin_sq)
      report("sin_sq_sum", longint'($signed(m_axis_tdata[127:80])), w.sin_sq);
    if (longint'($signed(m_axis_tdata[175:128])) != w.cos_sin)
      report("cos_sin_sum", longint'($signed(m_axis_tdata[175:128])), w.cos_sin);
    if (longint'($signed(m_axis_tdata[223:176])) != w.bsum)
      report("band_sum", longint'($signed(m_axis_tdata[223:176])), w.bsum);
    if (longint'($signed(m_axis_tdata[271:224])) != w.bcos)
      report("band_cos_diff", longint'($signed(m_axis_tdata[271:224])), w.bcos);
    if (longint'($signed(m_axis_tdata[319:272])) != w.bsin)
      report("band_sin_diff", longint'($signed(m_axis_tdata[319:272])), w.bsin);
  endtask

  // Offer one transfer, hold until accepted, then maybe idle.
  task automatic send_item(stim_row_t r, bit gaps);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.rq;
    s_axis_tdata  <= {5'b0, r.geo, r.tdiff, r.tsum, r.angle, r.band, r.pixel};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bin_sample(r);
    n_sent++;
    if (n_sent == 300) hold_req = 1'b1;
    if (gaps && !calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic bit [23:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(0, 200)) - 100);
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    m_axis_tready = 1'b0;
    forever begin : rx_loop
      int idle_left;
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) check_read();
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (idle_left > 0) begin
        idle_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        idle_left = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    stim_row_t table_rows [$];
    stim_row_t r;
    pix_sums_t zero_sums;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = '0;
    errors = 0;
    calm   = 1'b0;
    fill_sine_tab();
    foreach (hot_pixels[k]) hot_pixels[k] = 16'($urandom);
    hot_pixels[0] = 16'h0000;
    hot_pixels[1] = 16'hFFFF;
    zero_sums = '{0, 0, 0, 0, 0, 0, 0};
    table_rows = '{
      '{REQ_READ, 16'h0000, 2'd0, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b1, zero_sums},
      '{REQ_READ, 16'hFFFF, 2'd3, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, zero_sums},
      '{REQ_ACC,  16'h0000, 2'd0, 16'h0000, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0, zero_sums},
      '{REQ_ACC,  16'h0000, 2'd0, 16'h2000, 24'h800000, 24'h800000, 1'b1, 1'b0, zero_sums},
      '{REQ_ACC,  16'h0000, 2'd1, 16'h4000, 24'h000005, 24'h7FFFFF, 1'b0, 1'b0, zero_sums},
      '{REQ_ACC,  16'h0000, 2'd1, 16'h6000, 24'hFFFFFB, 24'h800000, 1'b1, 1'b0, zero_sums},
      '{REQ_ACC,  16'hFFFF, 2'd3, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, zero_sums},
      '{REQ_ACC,  16'hFFFF, 2'd3, 16'h0008, 24'h000001, 24'h000001, 1'b0, 1'b0, zero_sums},
      '{REQ_ACC,  16'hFFFF, 2'd2, 16'h1FF8, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0, zero_sums},
      '{REQ_ACC,  16'hFFFF, 2'd2, 16'hA5A5, 24'h5A5A5A, 24'hA5A5A5, 1'b1, 1'b0, zero_sums},
      '{REQ_READ, 16'h0000, 2'd0, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b0, zero_sums},
      '{REQ_READ, 16'h0000, 2'd1, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b0, zero_sums},
      '{REQ_READ, 16'h0000, 2'd2, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b0, zero_sums},
      '{REQ_READ, 16'hFFFF, 2'd3, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b0, zero_sums},
      '{REQ_READ, 16'hFFFF, 2'd2, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b0, zero_sums},
      '{REQ_READ, 16'h3039, 2'd1, 16'h0000, 24'h000000, 24'h000000, 1'b0, 1'b1, zero_sums}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (table_rows[k]) send_item(table_rows[k], 1'b1);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n > N_RANDOM - 200) calm = 1'b1;
      r.rq    = ($urandom_range(0, 3) == 0) ? REQ_READ : REQ_ACC;
      r.pixel = ($urandom_range(0, 9) < 8) ? hot_pixels[$urandom_range(0, 7)] : 16'($urandom);
      r.band  = 2'($urandom);
      r.angle = 16'($urandom);
      r.tsum  = pick_sample();
      r.tdiff = pick_sample();
      r.geo   = 1'($urandom);
      r.typed = 1'b0;
      r.want  = zero_sums;
      send_item(r, 1'b1);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d transfers in, %0d read results checked, incl. a long output stall.",
             n_sent, n_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
